FILE: src/fss_pkg.sv
`timescale 1ns / 1ps

package fss_pkg;

  // Event codes carried in the op field
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_STRONGER = 3'd1,
    OP_WEAKER   = 3'd2,
    OP_NATURAL  = 3'd3,
    OP_ROTATE   = 3'd4,
    OP_OFF      = 3'd5,
    OP_TIMEOUT  = 3'd6
  } op_t;

  // Sweep mode codes
  localparam logic [1:0] SWEEP_STOP = 2'd0;
  localparam logic [1:0] SWEEP_45   = 2'd1;
  localparam logic [1:0] SWEEP_90   = 2'd2;
  localparam logic [1:0] SWEEP_180  = 2'd3;

  // Servo compare values
  localparam logic [11:0] POS_CENTER = 12'd1300;
  localparam logic [11:0] LIM180_LO  = 12'd349;
  localparam logic [11:0] LIM180_HI  = 12'd2410;
  localparam logic [11:0] LIM90_LO   = 12'd865;
  localparam logic [11:0] LIM90_HI   = 12'd1895;
  localparam logic [11:0] LIM45_LO   = 12'd1123;
  localparam logic [11:0] LIM45_HI   = 12'd1637;
  localparam logic [11:0] SWEEP_STEP = 12'd2;

  // EMA coefficients, Q16: alpha and one minus alpha
  localparam logic [15:0] ALPHA_Q16 = 16'd197;
  localparam logic [15:0] KEEP_Q16  = 16'd65339;
  localparam logic [16:0] HALF_Q16  = 17'd32768;

  // Ceiling of the level in natural wind
  localparam int NATURAL_TOP = 8;

  typedef struct packed {
    logic [19:0] smoothed;
    logic [3:0]  level;
  } ema_res_t;

  typedef struct packed {
    logic [3:0]  power_level;
    logic [3:0]  pwm_duty;
    logic        standby_pin;
    logic [11:0] servo_position;
    logic [1:0]  sweep_mode;
    logic        natural_on;
    logic        show_sweep_leds;
    logic        start_display_timer;
    logic        stop_app_timer;
  } result_t;

  // Fan PWM compare value; levels above the table take the last entry
  function automatic logic [3:0] power_duty(input logic [3:0] lvl);
    logic [3:0] duty;
    case (lvl)
      4'd0:    duty = 4'd0;
      4'd1:    duty = 4'd1;
      4'd2:    duty = 4'd2;
      4'd3:    duty = 4'd3;
      4'd4:    duty = 4'd4;
      4'd5:    duty = 4'd5;
      4'd6:    duty = 4'd6;
      4'd7:    duty = 4'd8;
      default: duty = 4'd10;
    endcase
    return duty;
  endfunction

endpackage

FILE: src/fss_if.sv
`timescale 1ns / 1ps

interface fss_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [3:0] gust_chance;
  logic [2:0] gust_pick;

  modport source (output valid, op, gust_chance, gust_pick, input ready);
  modport sink (input valid, op, gust_chance, gust_pick, output ready);
endinterface

interface fss_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  power_level;
  logic [3:0]  pwm_duty;
  logic        standby_pin;
  logic [11:0] servo_position;
  logic [1:0]  sweep_mode;
  logic        natural_on;
  logic        show_sweep_leds;
  logic        start_display_timer;
  logic        stop_app_timer;

  modport source (
    output valid, power_level, pwm_duty, standby_pin, servo_position, sweep_mode,
           natural_on, show_sweep_leds, start_display_timer, stop_app_timer,
    input  ready
  );
  modport sink (
    input  valid, power_level, pwm_duty, standby_pin, servo_position, sweep_mode,
           natural_on, show_sweep_leds, start_display_timer, stop_app_timer,
    output ready
  );
endinterface

FILE: src/fss_ema.sv
`timescale 1ns / 1ps

// One EMA step toward the gust target, Q4.16, rounded half up,
// then the level taken from the rounded average and clamped to 1..TOP_LEVEL.
module fss_ema #(
  parameter int TOP_LEVEL = 8
) (
  input  logic [3:0]         target,
  input  logic [19:0]        smoothed,
  output fss_pkg::ema_res_t  res
);

  logic [36:0] acc;
  logic [19:0] avg;
  logic [20:0] rounded;
  logic [4:0]  whole;

  assign acc = 37'(fss_pkg::ALPHA_Q16) * 37'({target, 16'h0000})
             + 37'(fss_pkg::KEEP_Q16) * 37'(smoothed)
             + 37'(fss_pkg::HALF_Q16);
  assign avg     = acc[35:16];
  assign rounded = {1'b0, avg} + 21'(fss_pkg::HALF_Q16);
  assign whole   = rounded[20:16];

  always_comb begin
    res.smoothed = avg;
    if (whole == 5'd0) begin
      res.level = 4'd1;
    end else if (whole > 5'(TOP_LEVEL)) begin
      res.level = 4'(TOP_LEVEL);
    end else begin
      res.level = whole[3:0];
    end
  end

endmodule

FILE: src/fan_speed_and_sweep_controller.sv
`timescale 1ns / 1ps
// A result passes through the input register and then the result register
// before it is offered; a held result holds the input.
// Throughput: one event per cycle while each result is taken; the whole
// update is one pass of logic.
// Reset (rst_n low, synchronous): fan off, sweep stopped at centre, wide
// limits, natural wind off, both channels empty.

module fan_speed_and_sweep_controller #(
  parameter int MAX_LEVEL     = 8,
  parameter int GUST_INTERVAL = 100
) (
  input logic          clk,
  input logic          rst_n,
  fss_in_if.sink       in_ch,
  fss_out_if.source    out_ch
);

  localparam int NAT_TOP = (MAX_LEVEL < fss_pkg::NATURAL_TOP) ? MAX_LEVEL
                                                              : fss_pkg::NATURAL_TOP;

  // Input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [2:0] s1_op_r;
  logic [3:0] s1_chance_r;
  logic [2:0] s1_pick_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  fss_pkg::result_t  result_r, result_nxt;

  // Controller state
  logic [3:0]  level_r, level_nxt;
  logic [3:0]  saved_r, saved_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic        up_r, up_nxt;
  logic [11:0] lo_r, lo_nxt;
  logic [11:0] hi_r, hi_nxt;
  logic        nat_r, nat_nxt;
  logic [6:0]  gcount_r, gcount_nxt;
  logic [3:0]  target_r, target_nxt;
  logic [19:0] smooth_r, smooth_nxt;
  logic        leds_r, leds_nxt;
  logic        start_pulse, stop_pulse;

  logic        in_xfer, advance;
  logic [12:0] pos_step;
  logic [7:0]  gcount_inc;
  logic        gust_wrap;
  logic [3:0]  target_tick;
  fss_pkg::ema_res_t ema;

  // Advance when the result slot is empty or being taken this cycle
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Sweep step: move two counts, clamp at a limit and turn round
  always_comb begin
    if (up_r) begin
      pos_step = {1'b0, pos_r} + 13'(fss_pkg::SWEEP_STEP);
    end else if (pos_r >= fss_pkg::SWEEP_STEP) begin
      pos_step = {1'b0, pos_r - fss_pkg::SWEEP_STEP};
    end else begin
      pos_step = 13'd0;
    end
  end

  // Gust interval: count ticks, maybe pick a new target at the end
  assign gcount_inc  = {1'b0, gcount_r} + 8'd1;
  assign gust_wrap   = gcount_inc[6:0] >= 7'(GUST_INTERVAL);
  assign target_tick = (gust_wrap && s1_chance_r == 4'd0) ? ({1'b0, s1_pick_r} + 4'd1)
                                                          : target_r;

  fss_ema #(
    .TOP_LEVEL (NAT_TOP)
  ) u_ema (
    .target   (target_tick),
    .smoothed (smooth_r),
    .res      (ema)
  );

  // Next state for the event in the input register
  always_comb begin
    level_nxt   = level_r;
    saved_nxt   = saved_r;
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    up_nxt      = up_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    nat_nxt     = nat_r;
    gcount_nxt  = gcount_r;
    target_nxt  = target_r;
    smooth_nxt  = smooth_r;
    leds_nxt    = leds_r;
    start_pulse = 1'b0;
    stop_pulse  = 1'b0;

    unique case (fss_pkg::op_t'(s1_op_r))
      fss_pkg::OP_TICK: begin
        if (mode_r != fss_pkg::SWEEP_STOP) begin
          if (pos_step >= {1'b0, hi_r}) begin
            pos_nxt = hi_r;
            up_nxt  = 1'b0;
          end else if (pos_step <= {1'b0, lo_r}) begin
            pos_nxt = lo_r;
            up_nxt  = 1'b1;
          end else begin
            pos_nxt = pos_step[11:0];
          end
        end
        if (nat_r && level_r != 4'd0) begin
          gcount_nxt = gust_wrap ? 7'd0 : gcount_inc[6:0];
          target_nxt = target_tick;
          smooth_nxt = ema.smoothed;
          if (ema.level != level_r) begin
            level_nxt = ema.level;
            leds_nxt  = 1'b0;
          end
        end
      end
      fss_pkg::OP_STRONGER: begin
        if (nat_r) begin
          // leave natural wind, restore the saved level
          level_nxt = saved_r;
          nat_nxt   = 1'b0;
          leds_nxt  = 1'b0;
        end else if (level_r < 4'(MAX_LEVEL)) begin
          level_nxt = level_r + 4'd1;
          leds_nxt  = 1'b0;
        end
      end
      fss_pkg::OP_WEAKER: begin
        if (nat_r) begin
          level_nxt = saved_r;
          nat_nxt   = 1'b0;
          leds_nxt  = 1'b0;
        end else if (level_r > 4'd1) begin
          level_nxt = level_r - 4'd1;
          leds_nxt  = 1'b0;
        end else begin
          // weakest setting: behave as the off event
          mode_nxt   = fss_pkg::SWEEP_STOP;
          level_nxt  = 4'd0;
          leds_nxt   = 1'b0;
          stop_pulse = 1'b1;
        end
      end
      fss_pkg::OP_NATURAL: begin
        if (level_r != 4'd0 && !nat_r) begin
          // enter natural wind, seed the average with the current level
          saved_nxt  = level_r;
          nat_nxt    = 1'b1;
          target_nxt = level_r;
          smooth_nxt = {level_r, 16'h0000};
          gcount_nxt = 7'd0;
        end else if (nat_r) begin
          level_nxt = saved_r;
          nat_nxt   = 1'b0;
          leds_nxt  = 1'b0;
        end
      end
      fss_pkg::OP_ROTATE: begin
        if (level_r != 4'd0) begin
          mode_nxt = mode_r + 2'd1;
          case (mode_r + 2'd1)
            fss_pkg::SWEEP_45: begin
              lo_nxt = fss_pkg::LIM45_LO;
              hi_nxt = fss_pkg::LIM45_HI;
            end
            fss_pkg::SWEEP_90: begin
              lo_nxt = fss_pkg::LIM90_LO;
              hi_nxt = fss_pkg::LIM90_HI;
            end
            fss_pkg::SWEEP_180: begin
              lo_nxt = fss_pkg::LIM180_LO;
              hi_nxt = fss_pkg::LIM180_HI;
            end
            default: begin
              // stopped: keep the previous limits
            end
          endcase
          leds_nxt    = 1'b1;
          start_pulse = 1'b1;
        end
      end
      fss_pkg::OP_OFF: begin
        // the saved level would be restored and then dropped: go straight to off
        mode_nxt   = fss_pkg::SWEEP_STOP;
        nat_nxt    = 1'b0;
        level_nxt  = 4'd0;
        leds_nxt   = 1'b0;
        stop_pulse = 1'b1;
      end
      fss_pkg::OP_TIMEOUT: begin
        leds_nxt = 1'b0;
      end
      default: begin
        // unused code: hold everything
      end
    endcase
  end

  // Result shows the state after the event
  always_comb begin
    result_nxt.power_level         = level_nxt;
    result_nxt.pwm_duty            = fss_pkg::power_duty(level_nxt);
    result_nxt.standby_pin         = (level_nxt == 4'd0);
    result_nxt.servo_position      = pos_nxt;
    result_nxt.sweep_mode          = mode_nxt;
    result_nxt.natural_on          = nat_nxt;
    result_nxt.show_sweep_leds     = leds_nxt;
    result_nxt.start_display_timer = start_pulse;
    result_nxt.stop_app_timer      = stop_pulse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= 4'd0;
      saved_r     <= 4'd0;
      mode_r      <= fss_pkg::SWEEP_STOP;
      pos_r       <= fss_pkg::POS_CENTER;
      up_r        <= 1'b1;
      lo_r        <= fss_pkg::LIM180_LO;
      hi_r        <= fss_pkg::LIM180_HI;
      nat_r       <= 1'b0;
      gcount_r    <= 7'd0;
      target_r    <= 4'd0;
      smooth_r    <= 20'd0;
      leds_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        level_r  <= level_nxt;
        saved_r  <= saved_nxt;
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        up_r     <= up_nxt;
        lo_r     <= lo_nxt;
        hi_r     <= hi_nxt;
        nat_r    <= nat_nxt;
        gcount_r <= gcount_nxt;
        target_r <= target_nxt;
        smooth_r <= smooth_nxt;
        leds_r   <= leds_nxt;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r     <= in_ch.op;
      s1_chance_r <= in_ch.gust_chance;
      s1_pick_r   <= in_ch.gust_pick;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.power_level         = result_r.power_level;
  assign out_ch.pwm_duty            = result_r.pwm_duty;
  assign out_ch.standby_pin         = result_r.standby_pin;
  assign out_ch.servo_position      = result_r.servo_position;
  assign out_ch.sweep_mode          = result_r.sweep_mode;
  assign out_ch.natural_on          = result_r.natural_on;
  assign out_ch.show_sweep_leds     = result_r.show_sweep_leds;
  assign out_ch.start_display_timer = result_r.start_display_timer;
  assign out_ch.stop_app_timer      = result_r.stop_app_timer;

`ifndef SYNTHESIS
  // Natural wind only runs with the fan on
  a_nat_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
    nat_r |-> (level_r != 4'd0))
    else $error("natural wind active at level zero");

  // Level stays within its range
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= 4'(MAX_LEVEL))
    else $error("level above maximum");

  // Turning off leaves everything quiet
  a_off_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stop_app_timer) |->
      (out_ch.power_level == 4'd0 && out_ch.sweep_mode == fss_pkg::SWEEP_STOP
       && !out_ch.natural_on && !out_ch.show_sweep_leds))
    else $error("off result with live state");

  // A sweep change always brings the sweep display up
  a_rotate_leds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.start_display_timer) |->
      (out_ch.show_sweep_leds && !out_ch.stop_app_timer))
    else $error("display timer start without sweep display");
`endif

endmodule

FILE: test/tb_fan_speed_and_sweep_controller.sv
`timescale 1ns / 1ps

module tb_fan_speed_and_sweep_controller;

  localparam int FAN_MAX_LEVEL = 8;
  localparam int GUST_PERIOD   = 100;
  localparam int PHASE_ITEMS   = 135;
  localparam int HOLD_CYCLES   = 60;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // Op code outside the event set: the block must leave its state alone
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [3:0] DUTY_TABLE [9] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
                                            4'd5, 4'd6, 4'd8, 4'd10};

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] chance;
    logic [2:0] pick;
  } fan_event_t;

  logic clk;
  logic rst_n;

  fss_in_if  in_ch ();
  fss_out_if out_ch ();

  fan_speed_and_sweep_controller #(
    .MAX_LEVEL     (FAN_MAX_LEVEL),
    .GUST_INTERVAL (GUST_PERIOD)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted controller state, kept in step with every accepted event
  logic [3:0]  fan_level;
  logic [3:0]  fan_saved_level;
  logic [1:0]  fan_sweep;
  logic [11:0] fan_pos;
  logic        fan_moving_up;
  logic [11:0] fan_lo_limit;
  logic [11:0] fan_hi_limit;
  logic        fan_breeze;
  logic [6:0]  fan_gust_count;
  logic [3:0]  fan_gust_target;
  logic [19:0] fan_smoothed;
  logic        fan_leds_sweep;

  fan_event_t        pending_events[$];
  fss_pkg::result_t  expected_results[$];

  fan_event_t        on_wire;
  fss_pkg::result_t  predicted;
  fss_pkg::result_t  want;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  logic        hold_go;
  int unsigned mismatch_count;
  int unsigned result_index;
  int unsigned cycle_count;
  int unsigned queued_in_phase;

  always #5 clk = ~clk;

  // Enter natural wind, or leave it and bring back the saved level
  task automatic breeze_toggle();
    if (fan_level > 0 && !fan_breeze) begin
      fan_saved_level = fan_level;
      fan_breeze      = 1'b1;
      fan_gust_target = fan_level;
      fan_smoothed    = {fan_level, 16'd0};
      fan_gust_count  = '0;
    end else if (fan_breeze) begin
      fan_level      = fan_saved_level;
      fan_breeze     = 1'b0;
      fan_leds_sweep = 1'b0;
    end
  endtask

  task automatic fan_shut_down();
    fan_sweep = fss_pkg::SWEEP_STOP;
    if (fan_breeze) breeze_toggle();
    fan_level      = '0;
    fan_leds_sweep = 1'b0;
  endtask

  // Advance the predicted state by one event and form the result it shows
  task automatic fan_apply(input fan_event_t ev, output fss_pkg::result_t res);
    int          step_pos;
    int          next_level;
    int          top;
    logic [63:0] acc;
    logic        start_pulse;
    logic        stop_pulse;
    start_pulse = 1'b0;
    stop_pulse  = 1'b0;
    top = (FAN_MAX_LEVEL < fss_pkg::NATURAL_TOP) ? FAN_MAX_LEVEL : fss_pkg::NATURAL_TOP;
    case (ev.op)
      fss_pkg::OP_TICK: begin
        if (fan_sweep != fss_pkg::SWEEP_STOP) begin
          step_pos = fan_pos;
          if (fan_moving_up) step_pos = step_pos + 2;
          else step_pos = (step_pos >= 2) ? step_pos - 2 : 0;
          if (step_pos >= fan_hi_limit) begin
            step_pos      = fan_hi_limit;
            fan_moving_up = 1'b0;
          end else if (step_pos <= fan_lo_limit) begin
            step_pos      = fan_lo_limit;
            fan_moving_up = 1'b1;
          end
          fan_pos = step_pos[11:0];
        end
        if (fan_breeze && fan_level > 0) begin
          fan_gust_count = fan_gust_count + 7'd1;
          if (fan_gust_count >= GUST_PERIOD) begin
            fan_gust_count = '0;
            if (ev.chance == 0) fan_gust_target = {1'b0, ev.pick} + 4'd1;
          end
          acc = 64'(fss_pkg::ALPHA_Q16) * 64'({fan_gust_target, 16'd0})
              + 64'(fss_pkg::KEEP_Q16) * 64'(fan_smoothed) + 64'(fss_pkg::HALF_Q16);
          fan_smoothed = acc[35:16];
          next_level = (32'(fan_smoothed) + 32768) >> 16;
          if (next_level < 1) next_level = 1;
          if (next_level > top) next_level = top;
          if (next_level != fan_level) begin
            fan_level      = next_level[3:0];
            fan_leds_sweep = 1'b0;
          end
        end
      end
      fss_pkg::OP_STRONGER: begin
        if (fan_breeze) begin
          breeze_toggle();
        end else if (fan_level < FAN_MAX_LEVEL) begin
          fan_level      = fan_level + 4'd1;
          fan_leds_sweep = 1'b0;
        end
      end
      fss_pkg::OP_WEAKER: begin
        if (fan_breeze) begin
          breeze_toggle();
        end else if (fan_level > 1) begin
          fan_level      = fan_level - 4'd1;
          fan_leds_sweep = 1'b0;
        end else begin
          fan_shut_down();
          stop_pulse = 1'b1;
        end
      end
      fss_pkg::OP_NATURAL: breeze_toggle();
      fss_pkg::OP_ROTATE: begin
        if (fan_level > 0) begin
          fan_sweep = fan_sweep + 2'd1;
          case (fan_sweep)
            fss_pkg::SWEEP_45: begin
              fan_lo_limit = fss_pkg::LIM45_LO;
              fan_hi_limit = fss_pkg::LIM45_HI;
            end
            fss_pkg::SWEEP_90: begin
              fan_lo_limit = fss_pkg::LIM90_LO;
              fan_hi_limit = fss_pkg::LIM90_HI;
            end
            fss_pkg::SWEEP_180: begin
              fan_lo_limit = fss_pkg::LIM180_LO;
              fan_hi_limit = fss_pkg::LIM180_HI;
            end
            default: ;
          endcase
          fan_leds_sweep = 1'b1;
          start_pulse    = 1'b1;
        end
      end
      fss_pkg::OP_OFF: begin
        fan_shut_down();
        stop_pulse = 1'b1;
      end
      fss_pkg::OP_TIMEOUT: fan_leds_sweep = 1'b0;
      default: ;
    endcase
    res.power_level         = fan_level;
    res.pwm_duty            = DUTY_TABLE[(fan_level > 8) ? 8 : fan_level];
    res.standby_pin         = (fan_level == 0);
    res.servo_position      = fan_pos;
    res.sweep_mode          = fan_sweep;
    res.natural_on          = fan_breeze;
    res.show_sweep_leds     = fan_leds_sweep;
    res.start_display_timer = start_pulse;
    res.stop_app_timer      = stop_pulse;
  endtask

  function automatic void push_event(logic [2:0] op, logic [3:0] chance, logic [2:0] pick);
    fan_event_t ev;
    ev.op     = op;
    ev.chance = chance;
    ev.pick   = pick;
    pending_events.push_back(ev);
    queued_in_phase++;
  endfunction

  task automatic flag_field(input string name, input int unsigned exp_v,
                            input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 name, result_index, exp_v, act_v);
    end
  endtask

  // Hold until nothing is queued, offered or outstanding
  task automatic wait_drained();
    while (pending_events.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: offer the next queued event, hold it until transferred, and
  // predict the result of every event the block takes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fan_apply(on_wire, predicted);
        expected_results.push_back(predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire = pending_events.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.op          <= on_wire.op;
          in_ch.gust_chance <= on_wire.chance;
          in_ch.gust_pick   <= on_wire.pick;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: compare each transferred result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with no event to account for it", result_index);
      end else begin
        want = expected_results.pop_front();
        flag_field("power_level", want.power_level, out_ch.power_level);
        flag_field("pwm_duty", want.pwm_duty, out_ch.pwm_duty);
        flag_field("standby_pin", want.standby_pin, out_ch.standby_pin);
        flag_field("servo_position", want.servo_position, out_ch.servo_position);
        flag_field("sweep_mode", want.sweep_mode, out_ch.sweep_mode);
        flag_field("natural_on", want.natural_on, out_ch.natural_on);
        flag_field("show_sweep_leds", want.show_sweep_leds, out_ch.show_sweep_leds);
        flag_field("start_display_timer", want.start_display_timer,
                   out_ch.start_display_timer);
        flag_field("stop_app_timer", want.stop_app_timer, out_ch.stop_app_timer);
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.op          = fss_pkg::OP_TICK;
    in_ch.gust_chance = '0;
    in_ch.gust_pick   = '0;
    out_ch.ready      = 1'b0;
    hold_go           = 1'b0;
    hold_left         = 0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    mismatch_count    = 0;
    result_index      = 0;
    cycle_count       = 0;
    queued_in_phase   = 0;

    fan_level       = '0;
    fan_saved_level = '0;
    fan_sweep       = fss_pkg::SWEEP_STOP;
    fan_pos         = fss_pkg::POS_CENTER;
    fan_moving_up   = 1'b1;
    fan_lo_limit    = fss_pkg::LIM180_LO;
    fan_hi_limit    = fss_pkg::LIM180_HI;
    fan_breeze      = 1'b0;
    fan_gust_count  = '0;
    fan_gust_target = '0;
    fan_smoothed    = '0;
    fan_leds_sweep  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: unknown op, the level-0 corner cases, the full climb with a
    // push at the top, every sweep mode, and leaving natural wind by stronger and by off
    push_event(OP_UNUSED, 4'd0, 3'd0);
    push_event(fss_pkg::OP_ROTATE, 4'd0, 3'd0);
    push_event(fss_pkg::OP_NATURAL, 4'd0, 3'd0);
    push_event(fss_pkg::OP_WEAKER, 4'd0, 3'd0);
    repeat (9) push_event(fss_pkg::OP_STRONGER, 4'd0, 3'd0);
    repeat (5) push_event(fss_pkg::OP_ROTATE, 4'd0, 3'd0);
    push_event(fss_pkg::OP_TICK, 4'd9, 3'd7);
    push_event(fss_pkg::OP_TIMEOUT, 4'd0, 3'd0);
    push_event(fss_pkg::OP_NATURAL, 4'd0, 3'd0);
    push_event(fss_pkg::OP_TICK, 4'd0, 3'd0);
    push_event(fss_pkg::OP_STRONGER, 4'd0, 3'd0);
    push_event(fss_pkg::OP_NATURAL, 4'd0, 3'd0);
    push_event(fss_pkg::OP_OFF, 4'd0, 3'd0);
    push_event(fss_pkg::OP_STRONGER, 4'd0, 3'd0);
    push_event(fss_pkg::OP_WEAKER, 4'd0, 3'd0);
    wait_drained();

    // Random phases: free-running, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      queued_in_phase = 0;
      while (queued_in_phase < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          // Noise: any event with any draws
          n = $urandom_range(8, 24);
          repeat (n) push_event(3'($urandom_range(0, 6)), 4'($urandom_range(0, 9)),
                                3'($urandom_range(0, 7)));
        end else begin
          // Natural-wind session: raise the fan, maybe start a sweep, enter
          // natural wind and tick past at least one gust interval
          repeat ($urandom_range(1, 4))
            push_event(fss_pkg::OP_STRONGER, 4'($urandom_range(0, 9)),
                       3'($urandom_range(0, 7)));
          repeat ($urandom_range(0, 2))
            push_event(fss_pkg::OP_ROTATE, 4'($urandom_range(0, 9)),
                       3'($urandom_range(0, 7)));
          push_event(fss_pkg::OP_NATURAL, 4'($urandom_range(0, 9)),
                     3'($urandom_range(0, 7)));
          n = $urandom_range(105, 180);
          repeat (n) begin
            if ($urandom_range(0, 59) == 0)
              push_event($urandom_range(0, 1) ? fss_pkg::OP_ROTATE : fss_pkg::OP_TIMEOUT,
                         4'd0, 3'd0);
            push_event(fss_pkg::OP_TICK,
                       $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 9)),
                       3'($urandom_range(0, 7)));
          end
          case ($urandom_range(0, 4))
            0: push_event(fss_pkg::OP_STRONGER, 4'd0, 3'd0);
            1: push_event(fss_pkg::OP_WEAKER, 4'd0, 3'd0);
            2: push_event(fss_pkg::OP_NATURAL, 4'd0, 3'd0);
            3: push_event(fss_pkg::OP_OFF, 4'd0, 3'd0);
            default: ;
          endcase
        end
      end
      // Stall the result side while events keep coming, so the block backs up
      if (ph == 0) begin
        hold_go <= 1'b1;
        @(negedge clk);
        hold_go <= 1'b0;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
